@@ sv/wsp_pkg.sv @@
package wsp_pkg;

  // Field widths
  localparam int unsigned COORD_W = 32;
  localparam int unsigned COEF_W  = 64;
  localparam int unsigned VIEW_W  = 14;
  localparam int unsigned HALF_W  = VIEW_W - 1;
  localparam int unsigned IDX_W   = 3;

  // Internal widths
  localparam int unsigned PROD_W = 2 * COORD_W;
  localparam int unsigned CLIP_W = 51;
  localparam int unsigned NUM_W  = 64;
  localparam int unsigned REM_W  = 84;
  localparam int unsigned QUO_W  = 33;
  localparam int unsigned SUM_W  = 35;

  // Pipeline depth: product, clip, numerator, range check, then one stage per quotient bit
  localparam int unsigned DIV_STAGES = QUO_W;
  localparam int unsigned PIPE_DEPTH = 4 + DIV_STAGES;

  // Smallest visible clip w, 0.1 in Q16.16
  localparam logic signed [CLIP_W-1:0] W_MIN = CLIP_W'(6554);

  // Register indexes
  localparam logic [IDX_W-1:0] REG_COEF_X_A = 3'd0;
  localparam logic [IDX_W-1:0] REG_COEF_X_B = 3'd1;
  localparam logic [IDX_W-1:0] REG_COEF_Y_A = 3'd2;
  localparam logic [IDX_W-1:0] REG_COEF_Y_B = 3'd3;
  localparam logic [IDX_W-1:0] REG_COEF_W_A = 3'd4;
  localparam logic [IDX_W-1:0] REG_COEF_W_B = 3'd5;
  localparam logic [IDX_W-1:0] REG_VIEW_W   = 3'd6;
  localparam logic [IDX_W-1:0] REG_VIEW_H   = 3'd7;

  localparam logic [VIEW_W-1:0] VIEW_W_RESET = 14'd1920;
  localparam logic [VIEW_W-1:0] VIEW_H_RESET = 14'd1080;

  // Flags that travel with a point through the divider
  typedef struct packed {
    logic vis;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } side_t;

endpackage

@@ sv/wsp_if.sv @@
interface wsp_point_if;
  logic                              valid;
  logic                              ready;
  logic signed [wsp_pkg::COORD_W-1:0] world_x;
  logic signed [wsp_pkg::COORD_W-1:0] world_y;
  logic signed [wsp_pkg::COORD_W-1:0] world_z;

  modport source (output valid, world_x, world_y, world_z, input ready);
  modport sink   (input valid, world_x, world_y, world_z, output ready);
endinterface

interface wsp_pixel_if;
  logic                              valid;
  logic                              ready;
  logic                              visible;
  logic signed [wsp_pkg::COORD_W-1:0] screen_x;
  logic signed [wsp_pkg::COORD_W-1:0] screen_y;

  modport source (output valid, visible, screen_x, screen_y, input ready);
  modport sink   (input valid, visible, screen_x, screen_y, output ready);
endinterface

@@ sv/world_to_screen_projection.sv @@
// channel   direction  payload
// points    in         world_x, world_y, world_z (signed Q16.16)
// pixels    out        visible, screen_x, screen_y (signed Q16.16)
// cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
// One point is accepted per cycle while the skid register is empty; each passes
// through 4 stages of products, clip sums, numerators and range check, then one stage
// per quotient bit (33) of the two shared-w dividers, then the output register.
// Reset clears valid bits and loads the register reset values.
// A stalled output is caught by a skid register; the pipeline holds only
// while that register is full.
module world_to_screen_projection (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [wsp_pkg::IDX_W-1:0]         cfg_index,
  input  logic [wsp_pkg::COEF_W-1:0]        cfg_data,
  wsp_point_if.sink                         points,
  wsp_pixel_if.source                       pixels
);

  localparam int unsigned CW = wsp_pkg::CLIP_W;
  localparam int unsigned RW = wsp_pkg::REM_W;
  localparam int unsigned QW = wsp_pkg::QUO_W;
  localparam int unsigned DN = wsp_pkg::DIV_STAGES;

  // Configuration
  logic [wsp_pkg::COEF_W-1:0] coef [6];
  logic [wsp_pkg::VIEW_W-1:0] view_w;
  logic [wsp_pkg::VIEW_W-1:0] view_h;
  logic [wsp_pkg::HALF_W-1:0] half_w;
  logic [wsp_pkg::HALF_W-1:0] half_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) coef[i] <= '0;
      view_w <= wsp_pkg::VIEW_W_RESET;
      view_h <= wsp_pkg::VIEW_H_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wsp_pkg::REG_COEF_X_A: coef[0] <= cfg_data;
        wsp_pkg::REG_COEF_X_B: coef[1] <= cfg_data;
        wsp_pkg::REG_COEF_Y_A: coef[2] <= cfg_data;
        wsp_pkg::REG_COEF_Y_B: coef[3] <= cfg_data;
        wsp_pkg::REG_COEF_W_A: coef[4] <= cfg_data;
        wsp_pkg::REG_COEF_W_B: coef[5] <= cfg_data;
        wsp_pkg::REG_VIEW_W:   view_w <= cfg_data[wsp_pkg::VIEW_W-1:0];
        wsp_pkg::REG_VIEW_H:   view_h <= cfg_data[wsp_pkg::VIEW_W-1:0];
      endcase
    end
  end

  assign half_w = view_w[wsp_pkg::VIEW_W-1:1];
  assign half_h = view_h[wsp_pkg::VIEW_W-1:1];

  // Pipeline control
  logic                                  en;
  logic [wsp_pkg::PIPE_DEPTH-1:0]        vld;
  logic                                  push;
  logic                                  ov;
  logic                                  sv;

  assign en           = !sv;
  assign points.ready = en;
  assign push         = en && vld[wsp_pkg::PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[wsp_pkg::PIPE_DEPTH-2:0], points.valid};
    end
  end

  // Stage A: nine products, row by term
  logic signed [wsp_pkg::PROD_W-1:0] prod [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        prod[r][0] <= points.world_x * $signed(coef[2*r][31:0]);
        prod[r][1] <= points.world_y * $signed(coef[2*r][63:32]);
        prod[r][2] <= points.world_z * $signed(coef[2*r+1][31:0]);
      end
    end
  end

  // Stage B: floor of the product sum, plus translation
  logic signed [CW-1:0] clip [3];
  logic signed [65:0]   psum [3];
  logic signed [CW-1:0] clip_next [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      psum[r] = 66'(prod[r][0]) + 66'(prod[r][1]) + 66'(prod[r][2]);
      clip_next[r] = $signed({psum[r][65], psum[r][65:16]})
                   + CW'($signed(coef[2*r+1][63:32]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) clip[r] <= clip_next[r];
    end
  end

  // Stage C: visibility, signs, magnitudes and numerators
  logic [wsp_pkg::NUM_W-1:0] num_x;
  logic [wsp_pkg::NUM_W-1:0] num_y;
  logic [CW-1:0]             wc;
  wsp_pkg::side_t            side_c;
  logic [CW-1:0]             mag_x;
  logic [CW-1:0]             mag_y;

  always_comb begin
    mag_x = clip[0][CW-1] ? CW'(-clip[0]) : CW'(clip[0]);
    mag_y = clip[1][CW-1] ? CW'(-clip[1]) : CW'(clip[1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_x        <= wsp_pkg::NUM_W'(half_w) * wsp_pkg::NUM_W'(mag_x);
      num_y        <= wsp_pkg::NUM_W'(half_h) * wsp_pkg::NUM_W'(mag_y);
      wc           <= clip[2];
      side_c.vis   <= clip[2] >= wsp_pkg::W_MIN;
      side_c.neg_x <= clip[0][CW-1];
      side_c.neg_y <= !clip[1][CW-1];
      side_c.ovf_x <= 1'b0;
      side_c.ovf_y <= 1'b0;
    end
  end

  // Stage D and divider: one quotient bit per stage
  logic [RW-1:0]  rx   [DN+1];
  logic [RW-1:0]  ry   [DN+1];
  logic [QW-1:0]  qx   [DN+1];
  logic [QW-1:0]  qy   [DN+1];
  logic [CW-1:0]  wd   [DN+1];
  wsp_pkg::side_t sd   [DN+1];
  wsp_pkg::side_t side_d;

  // Flag quotients whose integer part reaches 2^17
  always_comb begin
    side_d       = side_c;
    side_d.ovf_x = {4'b0, num_x} >= {wc, 17'b0};
    side_d.ovf_y = {4'b0, num_y} >= {wc, 17'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx[0]       <= {4'b0, num_x, 16'b0};
      ry[0]       <= {4'b0, num_y, 16'b0};
      qx[0]       <= '0;
      qy[0]       <= '0;
      wd[0]       <= wc;
      sd[0]       <= side_d;
    end
  end

  for (genvar k = 0; k < DN; k++) begin : g_div
    localparam int unsigned BIT = DN - 1 - k;
    logic [RW-1:0] trial;
    assign trial = RW'(wd[k]) << BIT;

    // Subtract the shifted divisor where it fits
    always_ff @(posedge clk) begin
      if (en) begin
        wd[k+1] <= wd[k];
        sd[k+1] <= sd[k];
        if (rx[k] >= trial) begin
          rx[k+1] <= rx[k] - trial;
          qx[k+1] <= qx[k] | (QW'(1) << BIT);
        end else begin
          rx[k+1] <= rx[k];
          qx[k+1] <= qx[k];
        end
        if (ry[k] >= trial) begin
          ry[k+1] <= ry[k] - trial;
          qy[k+1] <= qy[k] | (QW'(1) << BIT);
        end else begin
          ry[k+1] <= ry[k];
          qy[k+1] <= qy[k];
        end
      end
    end
  end

  // Final: offset by half size and saturate
  function automatic logic signed [31:0] place(
    input logic [wsp_pkg::HALF_W-1:0] half,
    input logic [QW-1:0]              q,
    input logic                       neg,
    input logic                       ovf
  );
    logic signed [wsp_pkg::SUM_W-1:0] hs;
    logic signed [wsp_pkg::SUM_W-1:0] qs;
    logic signed [wsp_pkg::SUM_W-1:0] s;
    hs = $signed(wsp_pkg::SUM_W'({half, 16'b0}));
    qs = $signed(wsp_pkg::SUM_W'(q));
    s  = neg ? hs - qs : hs + qs;
    if (ovf) begin
      place = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (s > wsp_pkg::SUM_W'(32'sh7FFF_FFFF)) begin
      place = 32'sh7FFF_FFFF;
    end else if (s < -(wsp_pkg::SUM_W'(36'sh8000_0000))) begin
      place = 32'sh8000_0000;
    end else begin
      place = s[31:0];
    end
  endfunction

  logic              res_vis;
  logic signed [31:0] res_x;
  logic signed [31:0] res_y;

  always_comb begin
    res_vis = sd[DN].vis;
    res_x   = res_vis ? place(half_w, qx[DN], sd[DN].neg_x, sd[DN].ovf_x) : '0;
    res_y   = res_vis ? place(half_h, qy[DN], sd[DN].neg_y, sd[DN].ovf_y) : '0;
  end

  // Output register and skid
  logic              sk_vis;
  logic signed [31:0] sk_x;
  logic signed [31:0] sk_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (!ov || pixels.ready) begin
      if (sv) begin
        ov <= 1'b1;
        sv <= 1'b0;
      end else begin
        ov <= push;
      end
    end else if (push) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov || pixels.ready) begin
      if (sv) begin
        pixels.visible  <= sk_vis;
        pixels.screen_x <= sk_x;
        pixels.screen_y <= sk_y;
      end else if (push) begin
        pixels.visible  <= res_vis;
        pixels.screen_x <= res_x;
        pixels.screen_y <= res_y;
      end
    end else if (push) begin
      sk_vis <= res_vis;
      sk_x   <= res_x;
      sk_y   <= res_y;
    end
  end

  assign pixels.valid = ov;

  // Checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst) sv |-> ov)
    else $error("skid holds a request while output is empty");
  a_skid_after_stall: assert property (@(posedge clk) disable iff (rst)
      $rose(sv) |-> $past(ov && !pixels.ready))
    else $error("skid filled without an output stall");
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
      (pixels.valid && !pixels.visible) |-> (pixels.screen_x == 0 && pixels.screen_y == 0))
    else $error("hidden point with nonzero coordinates");

endmodule
